### src/akv_pkg.sv
// Shared types and constants for the associative key/value table.
`timescale 1ns / 1ps
`default_nettype none
package akv_pkg;

   localparam int ACTION_BITS    = 3;
   localparam int STATUS_BITS    = 2;
   localparam int VALUE_OUT_BITS = 32;
   localparam int COUNT_BITS     = 7;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_INSERT    = 3'd0,
      ACT_SET_VALUE = 3'd1,
      ACT_RENAME    = 3'd2,
      ACT_DELETE    = 3'd3,
      ACT_LOOKUP    = 3'd4
   } akv_action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK      = 2'd0,
      STAT_EXISTS  = 2'd1,
      STAT_MISSING = 2'd2,
      STAT_FULL    = 2'd3
   } akv_status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SET_VALUE,
      OP_SET_KEY,
      OP_SHIFT
   } akv_op_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } akv_state_type;

   typedef struct packed {
      logic key_hit;
      logic new_key_hit;
   } akv_hit_type;

endpackage
`default_nettype wire

### src/akv_cell.sv
// One storage cell of the table: an entry, its key compares and its shift path.
`timescale 1ns / 1ps
`default_nettype none
module akv_cell #(
   parameter int CAPACITY   = 64,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   parameter int INDEX      = 0
) (
   input  logic                            clock,
   input  logic                            req_fire,
   input  logic [KEY_BITS-1:0]             req_key,
   input  logic [KEY_BITS-1:0]             req_new_key,
   input  akv_pkg::akv_op_type             cmd_op,
   input  logic [$clog2(CAPACITY)-1:0]     cmd_pos,
   input  logic [$clog2(CAPACITY+1)-1:0]   cmd_count,
   input  logic [KEY_BITS-1:0]             wr_key,
   input  logic [VALUE_BITS-1:0]           wr_value,
   input  logic [KEY_BITS-1:0]             wr_new_key,
   input  logic [KEY_BITS-1:0]             next_key,
   input  logic [VALUE_BITS-1:0]           next_value,
   output logic [KEY_BITS-1:0]             cell_key,
   output logic [VALUE_BITS-1:0]           cell_value,
   output akv_pkg::akv_hit_type            hit
);
   import akv_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   akv_hit_type           hit_ff, hit_in;
   logic                  occupied;

   assign occupied = (MY_POS < cmd_count);

   always_comb begin
      hit_in = hit_ff;
      if (req_fire) begin
         hit_in.key_hit     = occupied && (key_ff == req_key);
         hit_in.new_key_hit = occupied && (key_ff == req_new_key);
      end
   end

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      case (cmd_op)
         OP_INSERT: begin
            if (MY_IDX == cmd_pos) begin
               key_in   = wr_key;
               value_in = wr_value;
            end
         end
         OP_SET_VALUE: begin
            if (hit_ff.key_hit) begin
               value_in = wr_value;
            end
         end
         OP_SET_KEY: begin
            if (hit_ff.key_hit) begin
               key_in = wr_new_key;
            end
         end
         OP_SHIFT: begin
            if (MY_IDX >= cmd_pos) begin
               key_in   = next_key;
               value_in = next_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      hit_ff   <= hit_in;
   end

   assign cell_key   = key_ff;
   assign cell_value = value_ff;
   assign hit        = hit_ff;

endmodule
`default_nettype wire

### src/associative_key_value_table.sv
// Top level of the associative key/value table: request control and the cell chain.
//
// A request (action, key, value, new_key) is taken on req_valid && req_ready.
// Each entry lives in a cell of a chain; all cells compare their key against
// the request keys in the cycle the request is taken and register the hits;
// in S_EXEC the controller then combines the cell hits, issues one command
// to the chain (write an entry, rewrite a value or key, or shift every later
// entry down by one place on delete) and loads the response register.
// The response (status, value_out, count) is loaded together with that
// command and is held until rsp_ready. Each request passes a compare
// cycle and a command cycle; req_ready is high again right after a response
// is loaded, so a new request can enter while the previous response still
// waits. If the receiver stalls with a response pending, the command cycle
// of the next request waits for it. Reset empties the table (count zero)
// and drops any pending response; no clearing pass is needed, entries at
// or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none
module associative_key_value_table #(
   parameter int CAPACITY   = 64,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [akv_pkg::ACTION_BITS-1:0]    req_action,
   input  logic [KEY_BITS-1:0]                req_key,
   input  logic [VALUE_BITS-1:0]              req_value,
   input  logic [KEY_BITS-1:0]                req_new_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [akv_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [akv_pkg::VALUE_OUT_BITS-1:0] rsp_value_out,
   output logic [akv_pkg::COUNT_BITS-1:0]     rsp_count
);
   import akv_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   akv_state_type state_ff, state_in;
   logic          req_fire;
   logic          commit;

   logic [ACTION_BITS-1:0] action_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [VALUE_BITS-1:0]  value_ff;
   logic [KEY_BITS-1:0]    new_key_ff;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                       rsp_valid_ff;
   akv_status_type             rsp_status_ff;
   logic [VALUE_OUT_BITS-1:0]  rsp_value_ff;
   logic [COUNT_BITS-1:0]      rsp_count_ff;

   logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
   logic [VALUE_BITS-1:0] cell_value [CAPACITY];
   akv_hit_type           cell_hit   [CAPACITY];
   logic [CAPACITY-1:0]   key_hits;
   logic [CAPACITY-1:0]   new_key_hits;
   logic                  any_key;
   logic                  any_new_key;
   logic [IDX_W-1:0]      hit_pos;
   logic [VALUE_BITS-1:0] hit_value;

   akv_op_type            op;
   akv_op_type            cell_op;
   logic [IDX_W-1:0]      op_pos;
   akv_status_type        status;
   logic [VALUE_BITS-1:0] value_out;
   logic [CNT_W-1:0]      count_next;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_EXEC: begin
            commit = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff  <= req_action;
         key_ff     <= req_key;
         value_ff   <= req_value;
         new_key_ff <= req_new_key;
      end
   end

   // Combine the registered hits of all cells.
   always_comb begin
      hit_pos   = '0;
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         key_hits[i]     = cell_hit[i].key_hit;
         new_key_hits[i] = cell_hit[i].new_key_hit;
         if (cell_hit[i].key_hit) begin
            hit_pos   = hit_pos | IDX_W'(i);
            hit_value = hit_value | cell_value[i];
         end
      end
   end

   assign any_key     = |key_hits;
   assign any_new_key = |new_key_hits;

   always_comb begin
      op         = OP_HOLD;
      op_pos     = hit_pos;
      status     = STAT_OK;
      value_out  = '0;
      count_next = count_ff;
      case (akv_action_type'(action_ff))
         ACT_INSERT: begin
            if (any_key) begin
               status = STAT_EXISTS;
            end else if (count_ff == FULL_COUNT) begin
               status = STAT_FULL;
            end else begin
               op         = OP_INSERT;
               op_pos     = count_ff[IDX_W-1:0];
               count_next = count_ff + CNT_W'(1);
            end
         end
         ACT_SET_VALUE: begin
            if (!any_key) begin
               status = STAT_MISSING;
            end else begin
               op = OP_SET_VALUE;
            end
         end
         ACT_RENAME: begin
            if (any_new_key) begin
               status = STAT_EXISTS;
            end else if (!any_key) begin
               status = STAT_MISSING;
            end else begin
               op = OP_SET_KEY;
            end
         end
         ACT_DELETE: begin
            if (!any_key) begin
               status = STAT_MISSING;
            end else begin
               op         = OP_SHIFT;
               count_next = count_ff - CNT_W'(1);
            end
         end
         ACT_LOOKUP: begin
            if (!any_key) begin
               status = STAT_MISSING;
            end else begin
               value_out = hit_value;
            end
         end
         default: begin
         end
      endcase
   end

   assign cell_op  = commit ? op : OP_HOLD;
   assign count_in = commit ? count_next : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= status;
         rsp_value_ff  <= VALUE_OUT_BITS'(value_out);
         rsp_count_ff  <= COUNT_BITS'(count_next);
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [KEY_BITS-1:0]   nbr_key;
         logic [VALUE_BITS-1:0] nbr_value;
         if (g + 1 < CAPACITY) begin : g_mid
            assign nbr_key   = cell_key[g+1];
            assign nbr_value = cell_value[g+1];
         end else begin : g_last
            assign nbr_key   = cell_key[g];
            assign nbr_value = cell_value[g];
         end
         akv_cell #(
            .CAPACITY   (CAPACITY),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (g)
         ) u_cell (
            .clock       (clock),
            .req_fire    (req_fire),
            .req_key     (req_key),
            .req_new_key (req_new_key),
            .cmd_op      (cell_op),
            .cmd_pos     (op_pos),
            .cmd_count   (count_ff),
            .wr_key      (key_ff),
            .wr_value    (value_ff),
            .wr_new_key  (new_key_ff),
            .next_key    (nbr_key),
            .next_value  (nbr_value),
            .cell_key    (cell_key[g]),
            .cell_value  (cell_value[g]),
            .hit         (cell_hit[g])
         );
      end
   endgenerate

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_count     = rsp_count_ff;

   // Keys are unique, so at most one cell can match the request key.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> $onehot0(key_hits))
      else $error("more than one cell matched the request key");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds capacity");

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("command cycle did not load a response");

   a_stall_holds_table: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(count_ff))
      else $error("table changed while a response was stalled");

endmodule
`default_nettype wire

### tb/associative_key_value_table_tb.sv
// Testbench for the associative key/value table: directed, full-table, stall and random tests.
`timescale 1ns / 1ps
module associative_key_value_table_tb;
   import akv_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int POOL_SIZE   = 96;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 540;
   localparam int PRINT_LIMIT = 100;
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED_MID   = 3'd6;
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      akv_status_type        status;
      logic [VALUE_BITS-1:0] value_out;
      logic [COUNT_BITS-1:0] count;
   } table_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ACTION_BITS-1:0] req_action = '0;
   logic [KEY_BITS-1:0]    req_key = '0;
   logic [VALUE_BITS-1:0]  req_value = '0;
   logic [KEY_BITS-1:0]    req_new_key = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [VALUE_OUT_BITS-1:0] rsp_value_out;
   logic [COUNT_BITS-1:0]  rsp_count;

   logic [KEY_BITS-1:0]    stored_keys[CAPACITY];
   logic [VALUE_BITS-1:0]  stored_values[CAPACITY];
   int                     entry_total = 0;
   logic [KEY_BITS-1:0]    key_pool[POOL_SIZE];
   table_result_type       pending_results[$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   associative_key_value_table #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_key       (req_key),
      .req_value     (req_value),
      .req_new_key   (req_new_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_count     (rsp_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // The receiver stalls at random, and for a long stretch whenever a hold is requested.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %0h expected %0h",
                  cycle_count, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_status, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_value_out !== want.value_out)
               report_mismatch("value_out", rsp_value_out, want.value_out);
            if (rsp_count !== want.count)
               report_mismatch("count", rsp_count, want.count);
         end
      end
   end

   function automatic int find_entry(input logic [KEY_BITS-1:0] k);
      for (int i = 0; i < entry_total; i++)
         if (stored_keys[i] == k) return i;
      return -1;
   endfunction

   // Applies one request to the shadow table and returns the response it should produce.
   function automatic table_result_type apply_request(input logic [ACTION_BITS-1:0] act,
                                                      input logic [KEY_BITS-1:0] k,
                                                      input logic [VALUE_BITS-1:0] v,
                                                      input logic [KEY_BITS-1:0] nk);
      table_result_type r;
      int pos;
      r.status = STAT_OK;
      r.value_out = '0;
      case (act)
         ACT_INSERT: begin
            if (find_entry(k) >= 0) begin
               r.status = STAT_EXISTS;
            end else if (entry_total >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               stored_keys[entry_total] = k;
               stored_values[entry_total] = v;
               entry_total++;
            end
         end
         ACT_SET_VALUE: begin
            pos = find_entry(k);
            if (pos < 0) r.status = STAT_MISSING;
            else stored_values[pos] = v;
         end
         ACT_RENAME: begin
            if (find_entry(nk) >= 0) begin
               r.status = STAT_EXISTS;
            end else begin
               pos = find_entry(k);
               if (pos < 0) r.status = STAT_MISSING;
               else stored_keys[pos] = nk;
            end
         end
         ACT_DELETE: begin
            pos = find_entry(k);
            if (pos < 0) begin
               r.status = STAT_MISSING;
            end else begin
               for (int j = pos; j + 1 < entry_total; j++) begin
                  stored_keys[j] = stored_keys[j + 1];
                  stored_values[j] = stored_values[j + 1];
               end
               entry_total--;
            end
         end
         ACT_LOOKUP: begin
            pos = find_entry(k);
            if (pos < 0) r.status = STAT_MISSING;
            else r.value_out = stored_values[pos];
         end
         default: begin
         end
      endcase
      r.count = entry_total[COUNT_BITS-1:0];
      return r;
   endfunction

   // Called at a clock edge; returns at the edge where the request is accepted.
   task automatic send_request(input logic [ACTION_BITS-1:0] act, input logic [KEY_BITS-1:0] k,
                               input logic [VALUE_BITS-1:0] v, input logic [KEY_BITS-1:0] nk);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_key <= k;
      req_value <= v;
      req_new_key <= nk;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_results.push_back(apply_request(act, k, v, nk));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic set_idle(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
   endtask

   function automatic logic [KEY_BITS-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 20 && entry_total > 0) return stored_keys[$urandom_range(entry_total - 1)];
      if (r < 90) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [KEY_BITS-1:0] fresh_key();
      logic [KEY_BITS-1:0] k;
      do k = $urandom; while (find_entry(k) >= 0);
      return k;
   endfunction

   task automatic send_random_item();
      logic [ACTION_BITS-1:0] act;
      int r;
      r = $urandom_range(99);
      if (r < 5) act = ACTION_BITS'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
      else if (r < 36) act = ACT_INSERT;
      else if (r < 51) act = ACT_SET_VALUE;
      else if (r < 63) act = ACT_RENAME;
      else if (r < 82) act = ACT_DELETE;
      else act = ACT_LOOKUP;
      send_request(act, pick_key(), $urandom, pick_key());
   endtask

   task automatic test_basic_actions();
      send_request(ACT_DELETE, 32'h0, 32'h0, 32'h0);
      send_request(ACT_LOOKUP, '1, 32'h0, 32'h0);
      send_request(ACT_INSERT, 32'h0, 32'h0, '1);
      send_request(ACT_INSERT, '1, '1, 32'h0);
      send_request(ACT_INSERT, 32'h0, 32'h1234_5678, 32'h0);
      send_request(ACT_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_request(ACT_LOOKUP, '1, 32'h0, 32'h0);
      send_request(ACT_LOOKUP, 32'h5555_5555, 32'h0, 32'h0);
      send_request(ACT_SET_VALUE, '1, 32'h0, 32'h0);
      send_request(ACT_SET_VALUE, 32'h0, 32'hAAAA_AAAA, 32'h0);
      send_request(ACT_SET_VALUE, 32'h7777_0000, 32'h1, 32'h0);
      send_request(ACT_RENAME, 32'h0, 32'h0, '1);
      send_request(ACT_RENAME, 32'h0, 32'h0, 32'h0);
      send_request(ACT_RENAME, 32'hDEAD_0001, 32'h0, 32'hDEAD_0002);
      send_request(ACT_RENAME, 32'h0, '1, 32'h5A5A_A5A5);
      send_request(ACT_LOOKUP, 32'h5A5A_A5A5, 32'h0, 32'h0);
      send_request(ACT_UNUSED_FIRST, 32'h5A5A_A5A5, '1, '1);
      send_request(ACT_UNUSED_MID, '1, '1, '1);
      send_request(ACT_UNUSED_LAST, 32'h0, '1, 32'h0);
      send_request(ACT_DELETE, 32'h1357_9BDF, 32'h0, 32'h0);
      send_request(ACT_DELETE, 32'h5A5A_A5A5, 32'h0, 32'h0);
      send_request(ACT_LOOKUP, '1, 32'h0, 32'h0);
      send_request(ACT_DELETE, '1, 32'h0, 32'h0);
      send_request(ACT_LOOKUP, '1, 32'h0, 32'h0);
   endtask

   task automatic test_full_table();
      while (entry_total < CAPACITY)
         send_request(ACT_INSERT, fresh_key(), $urandom, $urandom);
      send_request(ACT_INSERT, fresh_key(), $urandom, 32'h0);
      send_request(ACT_INSERT, stored_keys[CAPACITY - 1], $urandom, 32'h0);
      send_request(ACT_LOOKUP, stored_keys[CAPACITY - 1], 32'h0, 32'h0);
      send_request(ACT_RENAME, stored_keys[CAPACITY - 1], 32'h0, fresh_key());
      send_request(ACT_RENAME, stored_keys[3], 32'h0, stored_keys[40]);
      send_request(ACT_SET_VALUE, stored_keys[0], '1, 32'h0);
      send_request(ACT_LOOKUP, stored_keys[0], 32'h0, 32'h0);
      send_request(ACT_DELETE, stored_keys[10], 32'h0, 32'h0);
      send_request(ACT_LOOKUP, stored_keys[10], 32'h0, 32'h0);
      send_request(ACT_LOOKUP, stored_keys[CAPACITY - 2], 32'h0, 32'h0);
      send_request(ACT_INSERT, fresh_key(), $urandom, 32'h0);
      send_request(ACT_INSERT, fresh_key(), $urandom, 32'h0);
      while (entry_total > 0) begin
         if ($urandom_range(1) == 0) send_request(ACT_DELETE, stored_keys[0], 32'h0, 32'h0);
         else send_request(ACT_DELETE, pick_key(), 32'h0, 32'h0);
      end
      send_request(ACT_LOOKUP, key_pool[0], 32'h0, 32'h0);
   endtask

   task automatic test_stalled_receiver();
      hold_requests++;
      repeat (24) send_random_item();
   endtask

   task automatic test_random_traffic(input int items);
      repeat (items) send_random_item();
   endtask

   initial begin
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idle(11, 77);
      test_basic_actions();
      drain_results();
      test_full_table();
      drain_results();
      test_random_traffic(PHASE_ITEMS);
      drain_results();
      test_stalled_receiver();
      drain_results();

      set_idle(77, 11);
      test_random_traffic(PHASE_ITEMS);
      drain_results();

      set_idle(0, 0);
      test_random_traffic(PHASE_ITEMS);
      drain_results();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
src/akv_pkg.sv
src/akv_cell.sv
src/associative_key_value_table.sv
tb/associative_key_value_table_tb.sv
